>>> sv/rrps_pkg.sv
// Shared types, codes and constants of the round-robin process scheduler.
package rrps_pkg;

    localparam int MAX_PROCS_DEF = 16;

    localparam int          TIME_W      = 16;
    localparam int          PID_W       = 8;
    localparam int          SLICE_W     = 8;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd2;

    // APB register map
    localparam int          APB_AW      = 3;
    localparam int          APB_DW      = 32;
    localparam logic        REG_SLICE   = 1'b0;

    localparam logic        CMD_CREATE  = 1'b0;
    localparam logic        CMD_RUN     = 1'b1;

    localparam logic [TIME_W-1:0] RUNS_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        STAT_CREATED = 2'd0,
        STAT_RAN     = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_QUEUE_RD,
        ST_TABLE_RD,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic              cmd;
        logic [PID_W-1:0]  process_id;
        logic [TIME_W-1:0] required_time;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PID_W-1:0]  ran_id;
        logic [TIME_W-1:0] cpu_used;
        logic [TIME_W-1:0] time_left;
        logic [TIME_W-1:0] run_count;
        logic              finished;
        logic              next_valid;
        logic [PID_W-1:0]  next_id;
    } result_t;

    // One process table row
    typedef struct packed {
        logic [TIME_W-1:0] total;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] cpu;
        logic [TIME_W-1:0] runs;
    } tbl_entry_t;

    // Control from the sequencer to the run queue
    typedef struct packed {
        logic rd_en;
        logic pop;
        logic push;
    } qctl_t;

endpackage

>>> sv/rrps_queue.sv
// Circular run queue of unfinished processes: memory, head and count, two read ports.
module rrps_queue #(
    parameter int MAX_PROCS = rrps_pkg::MAX_PROCS_DEF,
    parameter int IW        = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
    parameter int CW        = $clog2(MAX_PROCS + 1),
    parameter int EW        = IW + rrps_pkg::PID_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrps_pkg::qctl_t      ctrl,
    input  logic [EW-1:0]        push_data,
    output logic [CW-1:0]        count,
    output logic [EW-1:0]        head_data,
    output logic [EW-1:0]        next_data
);

    localparam logic [IW-1:0] LAST = IW'(MAX_PROCS - 1);
    localparam logic [IW:0]   DEPTH = (IW + 1)'(MAX_PROCS);

    logic [EW-1:0] mem [MAX_PROCS];

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EW-1:0] head_data_reg, next_data_reg;

    logic [IW-1:0] head_inc;
    logic [IW:0]   tail_sum;
    logic [IW-1:0] tail_idx;
    logic          push_ok;

    assign head_inc = (head_reg == LAST) ? '0 : head_reg + IW'(1);

    // Tail is head + count either way: a pop moves head up and count down together.
    assign tail_sum = {1'b0, head_reg} + (IW + 1)'(count_reg);
    assign tail_idx = (tail_sum >= DEPTH) ? IW'(tail_sum - DEPTH) : tail_sum[IW-1:0];

    assign push_ok = ctrl.push && (ctrl.pop || (count_reg != CW'(MAX_PROCS)));

    always_comb
    begin
        head_next  = ctrl.pop ? head_inc : head_reg;
        count_next = count_reg - CW'(ctrl.pop) + CW'(push_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail_idx] <= push_data;
        end
        if (ctrl.rd_en)
        begin
            head_data_reg <= mem[head_reg];
            next_data_reg <= mem[head_inc];
        end
    end

    assign count     = count_reg;
    assign head_data = head_data_reg;
    assign next_data = next_data_reg;

endmodule

>>> sv/round_robin_process_scheduler.sv
// Round-robin process scheduler top level: sequencer, process table, result register, APB.
//
// A create beat, or a run beat on an empty queue, goes to the respond state, which loads the
// result. A run beat on a non-empty queue issues the run-queue memory read of the head and
// the entry behind it at the accepting edge, reads the head's process-table row in the next
// cycle, and then updates the row, writes it back, requeues the process unless it finished
// and loads the result. item_ready stays low from acceptance until the result is loaded.
// A result still waiting in the output register stalls the next beat in its last cycle, but
// the next beat is still taken while it waits. slice_length sits at byte address 0 and
// resets to 2.
module round_robin_process_scheduler #(
    parameter int MAX_PROCS = rrps_pkg::MAX_PROCS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  rrps_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output rrps_pkg::result_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rrps_pkg::APB_AW-1:0]     paddr,
    input  logic [rrps_pkg::APB_DW-1:0]     pwdata,
    output logic [rrps_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int EW = IW + rrps_pkg::PID_W;
    localparam int TW = rrps_pkg::TIME_W;

    // ---------------- configuration ----------------
    logic [rrps_pkg::SLICE_W-1:0] slice_reg;
    logic                         reg_sel;

    assign reg_sel = (paddr[rrps_pkg::APB_AW-1] == rrps_pkg::REG_SLICE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? rrps_pkg::APB_DW'(slice_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= rrps_pkg::SLICE_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            slice_reg <= pwdata[rrps_pkg::SLICE_W-1:0];
        end
    end

    // ---------------- state ----------------
    rrps_pkg::state_t  state_reg, state_next;
    rrps_pkg::item_t   item_reg;
    logic [CW-1:0]     used_reg, used_next;
    logic              res_valid_reg, res_valid_next;
    rrps_pkg::result_t res_reg, res_next;
    logic              res_load;
    logic              out_free;

    // queue
    rrps_pkg::qctl_t   qctl;
    logic [EW-1:0]     push_data;
    logic [CW-1:0]     q_count;
    logic [EW-1:0]     q_head, q_next;

    rrps_queue #(
        .MAX_PROCS (MAX_PROCS),
        .IW        (IW),
        .CW        (CW),
        .EW        (EW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (qctl),
        .push_data (push_data),
        .count     (q_count),
        .head_data (q_head),
        .next_data (q_next)
    );

    // ---------------- process table ----------------
    rrps_pkg::tbl_entry_t tbl_mem [MAX_PROCS];
    rrps_pkg::tbl_entry_t tbl_rd_reg;
    rrps_pkg::tbl_entry_t tbl_wdata;
    logic [IW-1:0]        tbl_waddr;
    logic                 tbl_we;
    logic                 tbl_re;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rd_reg <= tbl_mem[q_head[IW-1:0]];
        end
    end

    // ---------------- slice update ----------------
    logic [TW-1:0]        slice_ext;
    logic [TW:0]          cpu_sum;
    rrps_pkg::tbl_entry_t upd;
    logic                 done;
    logic [IW-1:0]        run_slot;
    logic [IW-1:0]        new_slot;

    assign slice_ext = TW'(slice_reg);
    assign cpu_sum   = {1'b0, tbl_rd_reg.cpu} + {1'b0, slice_ext};
    assign run_slot  = q_head[IW-1:0];
    assign new_slot  = used_reg[IW-1:0];

    always_comb
    begin
        upd.total     = tbl_rd_reg.total;
        upd.cpu       = (cpu_sum > {1'b0, tbl_rd_reg.total}) ? tbl_rd_reg.total
                                                             : cpu_sum[TW-1:0];
        upd.remaining = (tbl_rd_reg.remaining > slice_ext) ? tbl_rd_reg.remaining - slice_ext
                                                           : '0;
        upd.runs      = (tbl_rd_reg.runs != rrps_pkg::RUNS_MAX) ? tbl_rd_reg.runs + TW'(1)
                                                                : tbl_rd_reg.runs;
    end

    assign done = (upd.remaining == '0);

    // ---------------- sequencer ----------------
    assign item_ready = (state_reg == rrps_pkg::ST_IDLE);
    assign out_free   = !res_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        qctl       = '0;
        push_data  = q_head;
        tbl_re     = 1'b0;
        tbl_we     = 1'b0;
        tbl_waddr  = run_slot;
        tbl_wdata  = upd;
        res_load   = 1'b0;
        res_next   = '0;

        unique case (state_reg)
            rrps_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    qctl.rd_en = (item.cmd == rrps_pkg::CMD_RUN);
                    if (item.cmd == rrps_pkg::CMD_RUN && q_count != '0)
                    begin
                        state_next = rrps_pkg::ST_QUEUE_RD;
                    end
                    else
                    begin
                        state_next = rrps_pkg::ST_RESPOND;
                    end
                end
            end

            rrps_pkg::ST_QUEUE_RD:
            begin
                tbl_re     = 1'b1;
                state_next = rrps_pkg::ST_TABLE_RD;
            end

            rrps_pkg::ST_TABLE_RD:
            begin
                if (out_free)
                begin
                    res_load  = 1'b1;
                    tbl_we    = 1'b1;
                    qctl.pop  = 1'b1;
                    // requeue unless finished
                    qctl.push = !done;

                    res_next.status    = rrps_pkg::STAT_RAN;
                    res_next.ran_id    = q_head[EW-1:IW];
                    res_next.cpu_used  = upd.cpu;
                    res_next.time_left = upd.remaining;
                    res_next.run_count = upd.runs;
                    res_next.finished  = done;
                    // with a single process left, the requeued one becomes the new head
                    if (q_count > CW'(1))
                    begin
                        res_next.next_valid = 1'b1;
                        res_next.next_id    = q_next[EW-1:IW];
                    end
                    else if (!done)
                    begin
                        res_next.next_valid = 1'b1;
                        res_next.next_id    = q_head[EW-1:IW];
                    end
                    state_next = rrps_pkg::ST_IDLE;
                end
            end

            rrps_pkg::ST_RESPOND:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = rrps_pkg::ST_IDLE;
                    if (item_reg.cmd == rrps_pkg::CMD_CREATE)
                    begin
                        res_next.ran_id = item_reg.process_id;
                        if (used_reg == CW'(MAX_PROCS))
                        begin
                            res_next.status = rrps_pkg::STAT_FULL;
                        end
                        else
                        begin
                            res_next.status    = rrps_pkg::STAT_CREATED;
                            res_next.time_left = item_reg.required_time;
                            tbl_we              = 1'b1;
                            tbl_waddr           = new_slot;
                            tbl_wdata.total     = item_reg.required_time;
                            tbl_wdata.remaining = item_reg.required_time;
                            tbl_wdata.cpu       = '0;
                            tbl_wdata.runs      = '0;
                            qctl.push           = 1'b1;
                            push_data           = {item_reg.process_id, new_slot};
                            used_next           = used_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        res_next.status = rrps_pkg::STAT_EMPTY;
                    end
                end
            end

            default:
            begin
                state_next = rrps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrps_pkg::ST_IDLE;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

>>> sim/rrps_checker.sv
// Scoreboard for the round-robin process scheduler: predicts every result beat and compares it.
`timescale 1ns / 100ps
module rrps_checker #(
    parameter int MAX_PROCS = rrps_pkg::MAX_PROCS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_ready,
    input  rrps_pkg::item_t             item,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  rrps_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [rrps_pkg::APB_AW-1:0] paddr,
    input  logic [rrps_pkg::APB_DW-1:0] pwdata,
    input  logic [rrps_pkg::APB_DW-1:0] prdata,
    output int                          fail_count,
    output int                          pending,
    output int                          created_cnt,
    output int                          full_cnt,
    output int                          ran_cnt,
    output int                          finished_cnt,
    output int                          empty_cnt
);
    import rrps_pkg::*;

    localparam logic [APB_AW-1:0] SLICE_ADDR = {REG_SLICE, 2'b00};

    logic [SLICE_W-1:0] slice;
    logic [PID_W-1:0]   pid_tbl   [MAX_PROCS];
    logic [TIME_W-1:0]  total_tbl [MAX_PROCS];
    logic [TIME_W-1:0]  left_tbl  [MAX_PROCS];
    logic [TIME_W-1:0]  cpu_tbl   [MAX_PROCS];
    logic [TIME_W-1:0]  runs_tbl  [MAX_PROCS];
    int                 procs_used;
    int                 run_order[$];
    result_t            due_results[$];
    int                 result_seq;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, predicted %0h",
                                      result_seq, name, got, want));
    endtask

    // Apply one command to the shadow table and queue, return the result it causes.
    function automatic result_t advance_scheduler(input item_t it);
        result_t           r;
        int                slot;
        int unsigned       cpu_sum;
        logic [TIME_W-1:0] left;
        logic [TIME_W-1:0] slice_ext;
        r = '0;
        slice_ext = TIME_W'(slice);
        if (it.cmd == CMD_CREATE)
        begin
            r.ran_id = it.process_id;
            if (procs_used >= MAX_PROCS)
            begin
                r.status = STAT_FULL;
                full_cnt++;
            end
            else
            begin
                slot = procs_used;
                pid_tbl[slot]   = it.process_id;
                total_tbl[slot] = it.required_time;
                left_tbl[slot]  = it.required_time;
                cpu_tbl[slot]   = '0;
                runs_tbl[slot]  = '0;
                procs_used++;
                run_order.push_back(slot);
                r.status    = STAT_CREATED;
                r.time_left = it.required_time;
                created_cnt++;
            end
        end
        else if (run_order.size() == 0)
        begin
            r.status = STAT_EMPTY;
            empty_cnt++;
        end
        else
        begin
            slot = run_order.pop_front();
            cpu_sum = 32'(cpu_tbl[slot]) + 32'(slice_ext);
            if (cpu_sum > 32'(total_tbl[slot]))
                cpu_sum = 32'(total_tbl[slot]);
            left = (left_tbl[slot] > slice_ext) ? left_tbl[slot] - slice_ext : '0;
            if (runs_tbl[slot] != RUNS_MAX)
                runs_tbl[slot]++;
            cpu_tbl[slot]  = cpu_sum[TIME_W-1:0];
            left_tbl[slot] = left;
            // requeue unless done
            if (left != '0)
                run_order.push_back(slot);
            else
                finished_cnt++;
            r.status    = STAT_RAN;
            r.ran_id    = pid_tbl[slot];
            r.cpu_used  = cpu_sum[TIME_W-1:0];
            r.time_left = left;
            r.run_count = runs_tbl[slot];
            r.finished  = (left == '0);
            if (run_order.size() != 0)
            begin
                r.next_valid = 1'b1;
                r.next_id    = pid_tbl[run_order[0]];
            end
            ran_cnt++;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            slice      = SLICE_RESET;
            procs_used = 0;
            run_order.delete();
            due_results.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                              result_seq));
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status",     32'(result.status),     32'(want.status));
                    check_field("ran_id",     32'(result.ran_id),     32'(want.ran_id));
                    check_field("cpu_used",   32'(result.cpu_used),   32'(want.cpu_used));
                    check_field("time_left",  32'(result.time_left),  32'(want.time_left));
                    check_field("run_count",  32'(result.run_count),  32'(want.run_count));
                    check_field("finished",   32'(result.finished),   32'(want.finished));
                    check_field("next_valid", 32'(result.next_valid), 32'(want.next_valid));
                    check_field("next_id",    32'(result.next_id),    32'(want.next_id));
                end
                result_seq++;
            end
            if (item_valid && item_ready)
                due_results.push_back(advance_scheduler(item));
            // writes to any other address are dropped
            if (psel && penable && pready && paddr == SLICE_ADDR)
            begin
                if (pwrite)
                    slice = pwdata[SLICE_W-1:0];
                else if (prdata[SLICE_W-1:0] !== slice)
                    report_mismatch($sformatf("slice_length read %0h, predicted %0h",
                                              prdata[SLICE_W-1:0], slice));
            end
        end
        pending = due_results.size();
    end

endmodule

>>> sim/tb_round_robin_process_scheduler.sv
// Testbench top for the round-robin process scheduler: command stimulus, APB setup, verdict.
`timescale 1ns / 100ps
module tb_round_robin_process_scheduler;
    import rrps_pkg::*;

    localparam int                PROCS           = MAX_PROCS_DEF;
    localparam int                RANDOM_ITEMS    = 1000;
    localparam int                ZERO_SLICE_RUNS = 40;
    localparam int                HOLD_CYCLES     = 200;
    localparam int                SETTLE_CYCLES   = 8;
    localparam longint            CYCLE_LIMIT     = 100_000;
    localparam logic [APB_AW-1:0] SLICE_ADDR      = {REG_SLICE, 2'b00};
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR   = {~REG_SLICE, 2'b00};

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    item_t             item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    result_t           result;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [APB_AW-1:0] paddr        = '0;
    logic [APB_DW-1:0] pwdata       = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int     fail_count, pending;
    int     created_cnt, full_cnt, ran_cnt, finished_cnt, empty_cnt;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_armed    = 1'b0;
    bit     hold_done     = 1'b0;
    int     hold_left     = 0;
    longint cycles        = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    round_robin_process_scheduler #(.MAX_PROCS(PROCS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    rrps_checker #(.MAX_PROCS(PROCS)) sched_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .created_cnt  (created_cnt),
        .full_cnt     (full_cnt),
        .ran_cnt      (ran_cnt),
        .finished_cnt (finished_cnt),
        .empty_cnt    (empty_cnt)
    );

    // Result side flow control; once armed, drop ready for one long stretch.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic item_t make_item(input logic cmd, input logic [PID_W-1:0] pid,
                                        input logic [TIME_W-1:0] t);
        item_t it;
        it.cmd           = cmd;
        it.process_id    = pid;
        it.required_time = t;
        return it;
    endfunction

    // Run beat with junk in the fields the block ignores.
    function automatic item_t run_item();
        return make_item(CMD_RUN, PID_W'($urandom_range(255)), TIME_W'($urandom_range(65535)));
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.cmd        = ($urandom_range(99) < 12) ? CMD_CREATE : CMD_RUN;
        it.process_id = PID_W'($urandom_range(255));
        case ($urandom_range(9))
            0:       it.required_time = $urandom_range(1) ? '1 : '0;
            1, 2:    it.required_time = TIME_W'($urandom_range(65535));
            3, 4, 5: it.required_time = TIME_W'($urandom_range(2000));
            default: it.required_time = TIME_W'($urandom_range(40));
        endcase
        return it;
    endfunction

    // Enter and leave at a falling edge; valid stays high for the caller to reuse or drop.
    task automatic offer(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            item       <= item_t'($urandom);
            @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_items(input int count);
        repeat (count)
            offer(random_item());
    endtask

    // Drop valid and wait for every outstanding result, then a few more cycles.
    task automatic settle();
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write with junk in the upper bits, then read back.
    task automatic program_slice(input logic [SLICE_W-1:0] value);
        apb_access(1'b1, SLICE_ADDR, {24'($urandom), value});
        apb_access(1'b0, SLICE_ADDR, '0);
    endtask

    initial
    begin
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 48;
        apb_access(1'b0, SLICE_ADDR, '0);

        // reset slice: empty queue, zero-time process, extremes, clamp on finish
        offer(make_item(CMD_RUN, 8'h00, 16'h0000));
        offer(make_item(CMD_CREATE, 8'hFF, 16'h0000));
        offer(make_item(CMD_CREATE, 8'h00, 16'hFFFF));
        offer(make_item(CMD_CREATE, 8'h5A, 16'h0003));
        repeat (5)
            offer(run_item());
        settle();

        program_slice(8'hFF);
        offer(make_item(CMD_CREATE, 8'hA5, 16'h0100));
        repeat (4)
            offer(run_item());
        settle();

        apb_access(1'b1, UNMAPPED_ADDR, '1);
        apb_access(1'b0, SLICE_ADDR, '0);

        // zero slice: a zero-time process still finishes, the long one only counts runs
        program_slice(8'h00);
        offer(make_item(CMD_CREATE, 8'h81, 16'h0000));
        repeat (ZERO_SLICE_RUNS)
            offer(run_item());
        settle();

        program_slice(SLICE_W'($urandom_range(3, 64)));
        random_items(RANDOM_ITEMS / 3);
        settle();

        send_idle_pct = 48;
        recv_idle_pct = 29;
        program_slice(8'hFF);
        random_items(RANDOM_ITEMS / 3);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_slice(8'h01);
        hold_armed = 1'b1;
        random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        settle();

        $display("covered %0d creates (%0d refused on a full table), %0d slices run, %0d done",
                 created_cnt + full_cnt, full_cnt, ran_cnt, finished_cnt);
        $display("plus %0d runs on an empty queue; slices 2, 255, 0, random, 1; %0d mismatches",
                 empty_cnt, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
